@@ sv/pwfs_pkg.sv @@
package pwfs_pkg;

  localparam int LEN_BITS_DEFAULT = 16;
  localparam int ACC_BITS = 32;
  localparam logic [7:0] MAX_DETAIL_LEN_RESET = 8'd255;
  localparam logic [28:0] DETAIL_FIELD = 29'd2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_BYTE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    WT_VARINT = 3'd0,
    WT_I64    = 3'd1,
    WT_LEN    = 3'd2,
    WT_SGROUP = 3'd3,
    WT_EGROUP = 3'd4,
    WT_I32    = 3'd5,
    WT_RSVD6  = 3'd6,
    WT_RSVD7  = 3'd7
  } wire_type_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] message_length;
    logic [7:0]  byte_value;
  } in_item_t;

  typedef struct packed {
    logic       detail_valid;
    logic       detail_restart;
    logic [7:0] detail_byte;
    logic       done_res;
    logic       parse_status;
  } out_item_t;

endpackage

@@ sv/pwfs_parser.sv @@
module pwfs_parser
  import pwfs_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  in_item_t  item,
  input  logic      cfg_we,
  input  logic [7:0] cfg_data,
  output out_item_t result
);

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_TAG       = 8'b0000_0010,
    PH_VARVAL    = 8'b0000_0100,
    PH_LENSKIP   = 8'b0000_1000,
    PH_LENDETAIL = 8'b0001_0000,
    PH_SKIP      = 8'b0010_0000,
    PH_COPY      = 8'b0100_0000,
    PH_DRAIN     = 8'b1000_0000
  } phase_t;

  localparam logic [3:0] NEED_FIXED64 = 4'd8;
  localparam logic [3:0] NEED_FIXED32 = 4'd4;
  localparam logic [3:0] VARINT_LAST = 4'd9;
  localparam logic [6:0] SHIFT_CAP = 7'd63;
  localparam logic [63:0] HI_MASK = ~((64'd1 << LEN_BITS) - 64'd1);

  logic [7:0]          max_detail_len;
  phase_t              phase, phase_next;
  logic [ACC_BITS-1:0] acc_lo, acc_lo_next;
  logic                acc_hi, acc_hi_next;
  logic [3:0]          vshift, vshift_next;
  logic [LEN_BITS-1:0] consumed, consumed_next;
  logic [LEN_BITS-1:0] total, total_next;
  logic [LEN_BITS-1:0] skip, skip_next;
  logic [7:0]          copy, copy_next;
  logic                stopped, stopped_next;
  logic                first, first_next;

  logic [6:0]          shamt_raw;
  logic [5:0]          shamt;
  logic [63:0]         shifted;
  logic [ACC_BITS-1:0] fed_lo;
  logic                fed_hi;
  logic                fin;
  logic [LEN_BITS-1:0] cons_inc;
  logic [LEN_BITS-1:0] remaining;
  logic [LEN_BITS-1:0] len_n;
  logic                len_bad;
  logic [LEN_BITS-1:0] max_ext;
  logic [LEN_BITS-1:0] copy_cnt;
  logic [LEN_BITS-1:0] skip_dec;
  logic [7:0]          copy_dec;

  always_comb begin
    shamt_raw = 7'(vshift) * 7'd7;
    shamt     = (shamt_raw > SHIFT_CAP) ? SHIFT_CAP[5:0] : shamt_raw[5:0];
    shifted   = {57'd0, item.byte_value[6:0]} << shamt;
    fed_lo    = acc_lo | shifted[ACC_BITS-1:0];
    fed_hi    = acc_hi | (|(shifted & HI_MASK));
    fin       = !item.byte_value[7];
    cons_inc  = consumed + LEN_BITS'(1);
    remaining = total - cons_inc;
    len_n     = fed_lo[LEN_BITS-1:0];
    len_bad   = fed_hi || (len_n > remaining);
    max_ext   = LEN_BITS'(max_detail_len);
    copy_cnt  = (len_n < max_ext) ? len_n : max_ext;
    skip_dec  = (skip != '0) ? skip - LEN_BITS'(1) : skip;
    copy_dec  = (copy != '0) ? copy - 8'd1 : copy;
  end

  always_comb begin
    phase_next    = phase;
    acc_lo_next   = acc_lo;
    acc_hi_next   = acc_hi;
    vshift_next   = vshift;
    consumed_next = consumed;
    total_next    = total;
    skip_next     = skip;
    copy_next     = copy;
    stopped_next  = stopped;
    first_next    = first;
    result        = '0;

    if (item.op == OP_START) begin
      total_next    = LEN_BITS'(item.message_length);
      consumed_next = '0;
      skip_next     = '0;
      copy_next     = '0;
      stopped_next  = 1'b0;
      acc_lo_next   = '0;
      acc_hi_next   = 1'b0;
      vshift_next   = '0;
      phase_next    = PH_TAG;
      if (total_next == '0) begin
        result.done_res = 1'b1;
        phase_next      = PH_IDLE;
      end
    end else if (phase != PH_IDLE) begin
      consumed_next = cons_inc;
      unique case (phase)
        PH_TAG, PH_VARVAL, PH_LENSKIP, PH_LENDETAIL: begin
          acc_lo_next = fed_lo;
          acc_hi_next = fed_hi;
          if (!fin) begin
            if (vshift >= VARINT_LAST) begin
              stopped_next = 1'b1;
              phase_next   = PH_DRAIN;
            end else begin
              vshift_next = vshift + 4'd1;
            end
          end else if (phase == PH_TAG) begin
            case (wire_type_t'(fed_lo[2:0]))
              WT_VARINT: begin
                acc_lo_next = '0;
                acc_hi_next = 1'b0;
                vshift_next = '0;
                phase_next  = PH_VARVAL;
              end
              WT_LEN: begin
                acc_lo_next = '0;
                acc_hi_next = 1'b0;
                vshift_next = '0;
                phase_next  = (fed_lo[ACC_BITS-1:3] == DETAIL_FIELD) ? PH_LENDETAIL
                                                                      : PH_LENSKIP;
              end
              WT_I64, WT_I32: begin
                if (remaining < LEN_BITS'((fed_lo[2:0] == WT_I64) ? NEED_FIXED64
                                                                 : NEED_FIXED32)) begin
                  stopped_next = 1'b1;
                  phase_next   = PH_DRAIN;
                end else begin
                  skip_next  = LEN_BITS'((fed_lo[2:0] == WT_I64) ? NEED_FIXED64
                                                                 : NEED_FIXED32);
                  phase_next = PH_SKIP;
                end
              end
              default: begin
                stopped_next = 1'b1;
                phase_next   = PH_DRAIN;
              end
            endcase
          end else if (phase == PH_VARVAL) begin
            acc_lo_next = '0;
            acc_hi_next = 1'b0;
            vshift_next = '0;
            phase_next  = PH_TAG;
          end else if (len_bad) begin
            stopped_next = 1'b1;
            phase_next   = PH_DRAIN;
          end else if (len_n == '0) begin
            acc_lo_next = '0;
            acc_hi_next = 1'b0;
            vshift_next = '0;
            phase_next  = PH_TAG;
          end else if (phase == PH_LENDETAIL && max_detail_len != 8'd0) begin
            copy_next  = copy_cnt[7:0];
            skip_next  = len_n - copy_cnt;
            first_next = 1'b1;
            phase_next = PH_COPY;
          end else begin
            skip_next  = len_n;
            phase_next = PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_next = skip_dec;
          if (skip_dec == '0) begin
            acc_lo_next = '0;
            acc_hi_next = 1'b0;
            vshift_next = '0;
            phase_next  = PH_TAG;
          end
        end
        PH_COPY: begin
          result.detail_valid   = 1'b1;
          result.detail_byte    = item.byte_value;
          result.detail_restart = first;
          first_next            = 1'b0;
          copy_next             = copy_dec;
          if (copy_dec == 8'd0) begin
            if (skip != '0) begin
              phase_next = PH_SKIP;
            end else begin
              acc_lo_next = '0;
              acc_hi_next = 1'b0;
              vshift_next = '0;
              phase_next  = PH_TAG;
            end
          end
        end
        default: begin
        end
      endcase
      if (cons_inc == total) begin
        result.done_res     = 1'b1;
        result.parse_status = stopped_next || (phase_next != PH_TAG) ||
                              (vshift_next != 4'd0);
        phase_next          = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_detail_len <= MAX_DETAIL_LEN_RESET;
      phase          <= PH_IDLE;
      acc_lo         <= '0;
      acc_hi         <= 1'b0;
      vshift         <= '0;
      consumed       <= '0;
      total          <= '0;
      skip           <= '0;
      copy           <= '0;
      stopped        <= 1'b0;
      first          <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_detail_len <= cfg_data;
      end
      if (item_valid) begin
        phase    <= phase_next;
        acc_lo   <= acc_lo_next;
        acc_hi   <= acc_hi_next;
        vshift   <= vshift_next;
        consumed <= consumed_next;
        total    <= total_next;
        skip     <= skip_next;
        copy     <= copy_next;
        stopped  <= stopped_next;
        first    <= first_next;
      end
    end
  end

endmodule

@@ sv/pwfs_out_buf.sv @@
module pwfs_out_buf
  import pwfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_data,
  output logic      push_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      skid_valid;
  out_item_t skid_data;
  logic      pop;

  assign pop        = out_valid && out_ready;
  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push) begin
        if (!out_valid || pop) begin
          out_valid <= 1'b1;
          out_data  <= push_data;
        end else begin
          skid_valid <= 1'b1;
          skid_data  <= push_data;
        end
      end else if (pop) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

endmodule

@@ sv/protobuf_wire_field_scanner_core.sv @@
// Protocol-buffers wire-format field scanner. Every input transaction is
// either a message start carrying the byte count or one message byte, and
// each one yields exactly one result transaction, in order. The block takes
// one transaction per clock cycle while in_ready is high: the tag, length
// and value varint decode plus the skip and copy counters all update in the
// single next-state stage ahead of the result register. Results land in an
// output register backed by a one-entry skid register; in_ready drops only
// while both hold results that have not been taken. Up to max_detail_len
// leading bytes of each field 2 string come out with detail_valid set, the
// first of each flagged by detail_restart, and done_res with parse_status
// marks the end of each message. max_detail_len is written through the
// cfg channel and should only change while no message is in flight.
module protobuf_wire_field_scanner_core
  import pwfs_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic      accept;
  out_item_t result;

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  pwfs_parser #(
    .LEN_BITS(LEN_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .item_valid(accept),
    .item      (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  pwfs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .push_ready(in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ sv/pwfs_checker.sv @@
module pwfs_checker
  import pwfs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("Input stalled with no result waiting.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result changed.");

  a_empty_message: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid && in_data.op == OP_START &&
    in_data.message_length == 16'd0
    |=> out_valid && out_data.done_res && !out_data.parse_status)
    else $error("Empty message did not complete at once.");

  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.parse_status || out_data.done_res) &&
                  (!out_data.detail_restart || out_data.detail_valid))
    else $error("Inconsistent result flags.");

endmodule

bind protobuf_wire_field_scanner_core pwfs_checker u_checker (.*);

@@ tb/tb_protobuf_wire_field_scanner_core.sv @@
module tb_protobuf_wire_field_scanner_core
  import pwfs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_GOAL = 1850;
  localparam int PHASES = 8;
  localparam int NUM_PROBES = 27;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [28:0] DISCARD_FIELD = 29'd1;

  typedef enum logic [2:0] {
    SC_IDLE, SC_TAG, SC_VARVAL, SC_LENSKIP, SC_LENDETAIL, SC_SKIP, SC_COPY, SC_DRAIN
  } scan_phase_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} stall_mode_t;

  typedef struct packed {
    logic       cap_write;
    logic [7:0] cap;
    in_item_t   item;
    logic       pinned;
    out_item_t  want;
  } probe_row_t;

  localparam out_item_t OUT_QUIET = '0;
  localparam out_item_t OUT_DONE_OK = '{1'b0, 1'b0, 8'h00, 1'b1, 1'b0};
  localparam out_item_t OUT_DONE_STOPPED = '{1'b0, 1'b0, 8'h00, 1'b1, 1'b1};

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  scan_phase_t sc_phase = SC_IDLE;
  logic [63:0] sc_acc = '0;
  logic [3:0]  sc_shift = '0;
  logic [15:0] sc_consumed = '0;
  logic [15:0] sc_msg_len = '0;
  logic [15:0] sc_skip_left = '0;
  logic [7:0]  sc_copy_left = '0;
  logic        sc_stopped = 1'b0;
  logic [7:0]  sc_cap = MAX_DETAIL_LEN_RESET;

  out_item_t  expected_results[$];
  out_item_t  oldest_result;
  logic [7:0] msg_bytes[$];
  probe_row_t probes[NUM_PROBES];
  int         mismatch_count = 0;
  int         items_sent = 0;
  int         burst_left = 0;
  int         cycle_count = 0;

  protobuf_wire_field_scanner_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void stop_scan();
    sc_stopped = 1'b1;
    sc_phase = SC_DRAIN;
  endfunction

  function automatic void restart_varint(scan_phase_t nxt);
    sc_acc = '0;
    sc_shift = '0;
    sc_phase = nxt;
  endfunction

  function automatic logic take_varint_byte(logic [7:0] b);
    int sh;
    sh = int'(sc_shift) * 7;
    if (sh > 63) sh = 63;
    sc_acc = sc_acc | (64'(b[6:0]) << sh);
    if (!b[7]) return 1'b1;
    if (sc_shift >= 4'd9) begin
      stop_scan();
      return 1'b0;
    end
    sc_shift = sc_shift + 4'd1;
    return 1'b0;
  endfunction

  function automatic void take_tag(logic [15:0] left);
    logic [31:0] tag;
    int need;
    tag = sc_acc[31:0];
    case (wire_type_t'(tag[2:0]))
      WT_VARINT: restart_varint(SC_VARVAL);
      WT_LEN: restart_varint(tag[31:3] == DETAIL_FIELD ? SC_LENDETAIL : SC_LENSKIP);
      WT_I64, WT_I32: begin
        need = (wire_type_t'(tag[2:0]) == WT_I64) ? 8 : 4;
        if (int'(left) < need) begin
          stop_scan();
        end else begin
          sc_skip_left = 16'(need);
          sc_phase = SC_SKIP;
        end
      end
      default: stop_scan();
    endcase
  endfunction

  function automatic void take_length(logic [15:0] left, logic detail);
    logic [15:0] n;
    logic [7:0] c;
    if (sc_acc > 64'(left)) begin
      stop_scan();
      return;
    end
    n = sc_acc[15:0];
    if (n == 16'd0) begin
      restart_varint(SC_TAG);
    end else if (detail && sc_cap != 8'd0) begin
      c = (n < 16'(sc_cap)) ? n[7:0] : sc_cap;
      sc_copy_left = c;
      sc_skip_left = n - 16'(c);
      sc_acc = 64'd1;
      sc_phase = SC_COPY;
    end else begin
      sc_skip_left = n;
      sc_phase = SC_SKIP;
    end
  endfunction

  function automatic out_item_t scan_item(in_item_t it);
    out_item_t r;
    logic [15:0] left;
    logic detail;
    r = '0;
    if (it.op == OP_START) begin
      sc_msg_len = it.message_length;
      sc_consumed = '0;
      sc_skip_left = '0;
      sc_copy_left = '0;
      sc_stopped = 1'b0;
      restart_varint(SC_TAG);
      if (sc_msg_len == 16'd0) begin
        r.done_res = 1'b1;
        sc_phase = SC_IDLE;
      end
    end else if (sc_phase != SC_IDLE) begin
      sc_consumed = sc_consumed + 16'd1;
      left = sc_msg_len - sc_consumed;
      case (sc_phase)
        SC_TAG: begin
          if (take_varint_byte(it.byte_value)) take_tag(left);
        end
        SC_VARVAL: begin
          if (take_varint_byte(it.byte_value)) restart_varint(SC_TAG);
        end
        SC_LENSKIP, SC_LENDETAIL: begin
          detail = (sc_phase == SC_LENDETAIL);
          if (take_varint_byte(it.byte_value)) take_length(left, detail);
        end
        SC_SKIP: begin
          if (sc_skip_left != 16'd0) sc_skip_left = sc_skip_left - 16'd1;
          if (sc_skip_left == 16'd0) restart_varint(SC_TAG);
        end
        SC_COPY: begin
          r.detail_valid = 1'b1;
          r.detail_byte = it.byte_value;
          r.detail_restart = sc_acc[0];
          sc_acc = '0;
          if (sc_copy_left != 8'd0) sc_copy_left = sc_copy_left - 8'd1;
          if (sc_copy_left == 8'd0) begin
            if (sc_skip_left != 16'd0) sc_phase = SC_SKIP;
            else restart_varint(SC_TAG);
          end
        end
        default: ;
      endcase
      if (sc_consumed == sc_msg_len) begin
        r.done_res = 1'b1;
        r.parse_status = sc_stopped || sc_phase != SC_TAG || sc_shift != 4'd0;
        sc_phase = SC_IDLE;
      end
    end
    return r;
  endfunction

  task automatic send_item(in_item_t it, logic pinned, out_item_t want);
    int gap;
    out_item_t got;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 19) == 0) gap = 15;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    if (it.op == OP_START || sc_phase != SC_IDLE) items_sent++;
    got = scan_item(it);
    expected_results.push_back(pinned ? want : got);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_cap(logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sc_cap = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int varint_pad();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : 1;
  endfunction

  function automatic void put_varint(logic [63:0] v, int min_len);
    int cnt;
    logic more;
    cnt = 0;
    do begin
      cnt++;
      more = (v >> 7) != 64'd0 || cnt < min_len;
      msg_bytes.push_back({more, v[6:0]});
      v = v >> 7;
    end while (more);
  endfunction

  function automatic void put_tag(logic [28:0] fnum, wire_type_t wt);
    logic [63:0] v;
    v = {32'h0, fnum, wt};
    if ($urandom_range(0, 29) == 0) v[63:32] = $urandom;
    put_varint(v, varint_pad());
  endfunction

  function automatic void put_random(int n);
    repeat (n) msg_bytes.push_back(8'($urandom));
  endfunction

  function automatic logic [28:0] pick_field();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return DISCARD_FIELD;
    if (r < 55) return DETAIL_FIELD;
    if (r < 90) return 29'($urandom_range(3, 15));
    return 29'($urandom_range(16, 29'h1FFFFFFF));
  endfunction

  function automatic logic [63:0] pick_value();
    int bits;
    logic [63:0] v;
    bits = $urandom_range(1, 64);
    v = {$urandom, $urandom};
    if (bits < 64) v = v & ((64'd1 << bits) - 64'd1);
    return v;
  endfunction

  function automatic int pick_string_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 12);
    if (r < 93) return $urandom_range(13, 60);
    return $urandom_range(240, 300);
  endfunction

  function automatic void build_message();
    int nfields, kind, slen;
    wire_type_t bad;
    msg_bytes.delete();
    nfields = $urandom_range(0, 6);
    for (int f = 0; f < nfields; f++) begin
      kind = $urandom_range(0, 99);
      if (kind < 32) begin
        slen = pick_string_len();
        put_tag(DETAIL_FIELD, WT_LEN);
        put_varint(64'(slen), varint_pad());
        put_random(slen);
      end else if (kind < 50) begin
        put_tag(pick_field(), WT_VARINT);
        put_varint(pick_value(), varint_pad());
      end else if (kind < 62) begin
        slen = pick_string_len();
        put_tag(pick_field(), WT_LEN);
        put_varint(64'(slen), varint_pad());
        put_random(slen);
      end else if (kind < 72) begin
        put_tag(pick_field(), WT_I64);
        put_random(8);
      end else if (kind < 82) begin
        put_tag(pick_field(), WT_I32);
        put_random(4);
      end else if (kind < 88) begin
        put_tag(pick_field(), WT_LEN);
        put_varint(64'd0, varint_pad());
      end else if (kind < 91) begin
        put_tag(pick_field(), $urandom_range(0, 1) ? WT_I64 : WT_I32);
        put_random($urandom_range(0, 3));
        f = nfields;
      end else if (kind < 94) begin
        case ($urandom_range(0, 3))
          0: bad = WT_SGROUP;
          1: bad = WT_EGROUP;
          2: bad = WT_RSVD6;
          default: bad = WT_RSVD7;
        endcase
        put_tag(pick_field(), bad);
      end else if (kind < 97) begin
        if ($urandom_range(0, 1)) put_tag(pick_field(), WT_VARINT);
        repeat ($urandom_range(10, 11)) msg_bytes.push_back({1'b1, 7'($urandom)});
      end else begin
        put_tag(pick_field(), WT_LEN);
        put_varint({$urandom, $urandom} | 64'h10000, 1);
      end
    end
  endfunction

  task automatic send_message();
    int pick, sent;
    logic [15:0] mlen;
    in_item_t it;
    build_message();
    pick = $urandom_range(0, 99);
    sent = msg_bytes.size();
    mlen = 16'(msg_bytes.size());
    if (pick < 6) begin
      put_random($urandom_range(1, 6));
      sent = msg_bytes.size();
      mlen = 16'(sent);
    end else if (pick < 14) begin
      mlen = 16'($urandom_range(0, msg_bytes.size()));
      if (sent > int'(mlen) + 3) sent = int'(mlen) + 3;
    end else if (pick < 20) begin
      mlen = 16'($urandom_range(msg_bytes.size() + 1, 16'hFFFF));
    end
    if (sc_phase == SC_IDLE && $urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        it = '{op: OP_BYTE, message_length: 16'($urandom), byte_value: 8'($urandom)};
        send_item(it, 1'b0, OUT_QUIET);
      end
    end
    it = '{op: OP_START, message_length: mlen, byte_value: 8'($urandom)};
    send_item(it, 1'b0, OUT_QUIET);
    for (int i = 0; i < sent; i++) begin
      it = '{op: OP_BYTE, message_length: 16'($urandom), byte_value: msg_bytes[i]};
      send_item(it, 1'b0, OUT_QUIET);
    end
  endtask

  initial begin
    logic [7:0] phase_caps[PHASES];
    phase_caps = '{8'd255, 8'd1, 8'd0, 8'd12, 8'd254, 8'd5, 8'd37, 8'd255};
    probes = '{
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'hFF}, 1'b1, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_START, 16'h0000, 8'h00}, 1'b1, OUT_DONE_OK},
      '{1'b0, 8'd0, '{OP_START, 16'hFFFF, 8'h00}, 1'b1, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'hFF}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'hFF}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'hFF}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'hFF}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'hFF}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'hFF}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'hFF}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'hFF}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'hFF}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'hFF}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_START, 16'h0002, 8'h00}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'h09}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'h00}, 1'b1, OUT_DONE_STOPPED},
      '{1'b0, 8'd0, '{OP_START, 16'h0001, 8'h00}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'h0F}, 1'b1, OUT_DONE_STOPPED},
      '{1'b0, 8'd0, '{OP_START, 16'h0001, 8'h00}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'h80}, 1'b1, OUT_DONE_STOPPED},
      '{1'b0, 8'd0, '{OP_START, 16'h0002, 8'h00}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'h12}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'h05}, 1'b1, OUT_DONE_STOPPED},
      '{1'b1, 8'd0, '{OP_START, 16'h0003, 8'h00}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'h12}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'h01}, 1'b0, OUT_QUIET},
      '{1'b0, 8'd0, '{OP_BYTE, 16'h0000, 8'h55}, 1'b1, OUT_DONE_OK}
    };
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (probes[i]) begin
      if (probes[i].cap_write) begin
        settle();
        write_cap(probes[i].cap);
      end
      send_item(probes[i].item, probes[i].pinned, probes[i].want);
    end
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_cap(phase_caps[p]);
      while (items_sent < NUM_PROBES + (p + 1) * ITEM_GOAL / PHASES) send_message();
    end
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    stall_mode_t mode;
    int stretch;
    int tick;
    int holds_done;
    mode = RX_OPEN;
    stretch = 0;
    tick = 0;
    holds_done = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (holds_done < 2 && items_sent >= 300 + 900 * holds_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else begin
        if (stretch == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          stretch = $urandom_range(20, 150);
        end
        stretch--;
        tick++;
        case (mode)
          RX_OPEN: out_ready <= 1'b1;
          RX_COIN: out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (tick % 5 != 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected: %p", out_data);
        mismatch_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_data.detail_valid !== oldest_result.detail_valid) begin
          $error("detail_valid: expected %0d, actual %0d",
                 oldest_result.detail_valid, out_data.detail_valid);
          mismatch_count++;
        end
        if (out_data.detail_restart !== oldest_result.detail_restart) begin
          $error("detail_restart: expected %0d, actual %0d",
                 oldest_result.detail_restart, out_data.detail_restart);
          mismatch_count++;
        end
        if (out_data.detail_byte !== oldest_result.detail_byte) begin
          $error("detail_byte: expected 0x%02h, actual 0x%02h",
                 oldest_result.detail_byte, out_data.detail_byte);
          mismatch_count++;
        end
        if (out_data.done_res !== oldest_result.done_res) begin
          $error("done_res: expected %0d, actual %0d",
                 oldest_result.done_res, out_data.done_res);
          mismatch_count++;
        end
        if (out_data.parse_status !== oldest_result.parse_status) begin
          $error("parse_status: expected %0d, actual %0d",
                 oldest_result.parse_status, out_data.parse_status);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
